// File: rtl/hfa_pkg.sv
// hfa_pkg: operation codes, field constants and helpers for the half-float ALU.
// Depends on nothing; used by half_float_alu_core and hfa_checker.
package hfa_pkg;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_CMP = 3'd4
   } op_type;

   localparam int QUO_W = 16;   // dividend lifted by 5
   localparam logic [15:0] SIGN_MASK = 16'h8000;

   // Leading-one position of a 16-bit word, 0 when zero.
   function automatic logic [3:0] lead_one(input logic [15:0] v);
      logic [3:0] p;
      p = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (v[i]) p = 4'(i);
      end
      return p;
   endfunction

   // Significand with hidden bit; zero magnitude gives zero.
   function automatic logic [10:0] unpack_sig(input logic [15:0] h);
      return {(h[14:0] != 15'd0), h[9:0]};
   endfunction

endpackage

// File: rtl/half_float_alu_core.sv
// half_float_alu_core: pipelined truncating half-precision add/sub/mul/div/compare.
// Depends on hfa_pkg.
//
//  channel | ports                                   | direction
//  req     | req_valid req_stall req_op req_operand_* | in (stall out)
//  rsp     | rsp_valid rsp_stall rsp_result_bits ...  | out (stall in)
//
// A word accepted at one edge passes through one unpack stage, sixteen
// restoring divide stages (one quotient bit each), one align/sum stage,
// and the output register that normalizes and packs.
// One word enters per cycle while rsp is not stalled; the whole pipe advances when the output
// register is empty or being taken, so a stall freezes every stage.
// Synchronous active-high reset clears only the valid bits.
module half_float_alu_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_op,
   input  logic [15:0]          req_operand_a,
   input  logic [15:0]          req_operand_b,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [15:0]          rsp_result_bits,
   output logic signed [11:0]   rsp_compare_value,
   output logic                 rsp_divide_by_zero
);
   import hfa_pkg::*;

   localparam int NDIV = QUO_W;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] a;
      logic [15:0] b;
      logic        sa;
      logic        sb;
      logic signed [6:0] ea;  // unbiased
      logic signed [6:0] eb;
      logic [10:0] ma;
      logic [10:0] mb;
      logic [15:0] rem;       // divide partial remainder
      logic [15:0] quo;       // divide quotient bits
      logic [7:0]  dvs;       // divisor (mb >> 3)
   } item_type;

   // advance whole pipe whenever the output slot frees
   logic adv;
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // ---- stage 0: unpack
   item_type s0_ff;
   logic     v0_ff;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (adv) v0_ff <= req_valid;
      if (adv) begin
         s0_ff.op  <= req_op;
         s0_ff.a   <= req_operand_a;
         s0_ff.b   <= req_operand_b;
         s0_ff.sa  <= req_operand_a[15];
         s0_ff.sb  <= req_operand_b[15] ^ (req_op == OP_SUB);
         s0_ff.ea  <= 7'(signed'({2'b0, req_operand_a[14:10]})) - 7'sd15;
         s0_ff.eb  <= 7'(signed'({2'b0, req_operand_b[14:10]})) - 7'sd15;
         s0_ff.ma  <= unpack_sig(req_operand_a);
         s0_ff.mb  <= unpack_sig(req_operand_b);
         s0_ff.rem <= 16'd0;
         s0_ff.quo <= 16'd0;
         s0_ff.dvs <= {(req_operand_b[14:0] != 15'd0), req_operand_b[9:3]};
      end
   end

   // ---- divide stages: one restoring step each, dividend = ma << 5
   item_type dv_ff [NDIV];
   logic     dvv_ff [NDIV];
   for (genvar k = 0; k < NDIV; k++) begin : g_div
      item_type src, nxt;
      logic     srcv;
      logic [16:0] trial;
      logic [15:0] dividend;
      if (k == 0) begin : g_f
         assign src = s0_ff; assign srcv = v0_ff;
      end else begin : g_n
         assign src = dv_ff[k-1]; assign srcv = dvv_ff[k-1];
      end
      always_comb begin
         dividend = {src.ma, 5'd0};
         nxt = src;
         trial = {src.rem, dividend[NDIV-1-k]};
         if (trial >= {9'd0, src.dvs}) begin
            nxt.rem = 16'(trial - {9'd0, src.dvs});
            nxt.quo[NDIV-1-k] = 1'b1;
         end else begin
            nxt.rem = trial[15:0];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dvv_ff[k] <= 1'b0;
         else if (adv) dvv_ff[k] <= srcv;
         if (adv) dv_ff[k] <= nxt;
      end
   end

   item_type dlast;
   logic     dlastv;
   assign dlast  = dv_ff[NDIV-1];
   assign dlastv = dvv_ff[NDIV-1];

   // ---- stage A: align/sum, product, quotient pick, divide-by-zero flag, raw exponent, compare
   logic [15:0] raw_in, raw_ff;
   logic signed [7:0] exp_in, exp_ff;
   logic        rs_in, rs_ff;
   logic signed [11:0] cmp_in, cmp_ff;
   logic        dz_in, dz_ff;
   logic [2:0]  opa_ff;
   logic        va_ff;
   logic signed [7:0] d;
   logic [10:0] am, bm;
   logic signed [12:0] sum;
   logic signed [11:0] dir_v;
   always_comb begin
      raw_in = 16'd0; exp_in = 8'sd0; rs_in = 1'b0; cmp_in = 12'sd0; dz_in = 1'b0;
      am = dlast.ma; bm = dlast.mb; sum = 13'sd0; dir_v = 12'sd0;
      d = 8'(dlast.ea) - 8'(dlast.eb);
      case (dlast.op)
         OP_ADD, OP_SUB: begin
            if (d > 0) begin
               bm = (d >= 8'sd16) ? 11'd0 : (dlast.mb >> d[3:0]);
               exp_in = 8'(dlast.ea);
            end else begin
               am = (d <= -8'sd16) ? 11'd0 : (dlast.ma >> 4'(-d));
               exp_in = 8'(dlast.eb);
            end
            sum = (dlast.sa ? -13'(signed'({2'b0, am})) : 13'(signed'({2'b0, am})))
                + (dlast.sb ? -13'(signed'({2'b0, bm})) : 13'(signed'({2'b0, bm})));
            rs_in  = sum < 0;
            raw_in = rs_in ? 16'(-sum) : 16'(sum);
         end
         OP_MUL: begin
            raw_in = 16'(dlast.ma[10:3] * dlast.mb[10:3]);
            exp_in = 8'(dlast.ea) + 8'(dlast.eb) - 8'sd4;
            rs_in  = dlast.sa ^ dlast.sb;
         end
         OP_DIV: begin
            if (dlast.dvs == 8'd0) dz_in = 1'b1;
            else begin
               raw_in = dlast.quo;
               exp_in = 8'(dlast.ea) - 8'(dlast.eb) + 8'sd2;
               rs_in  = dlast.sa ^ dlast.sb;
            end
         end
         OP_CMP: begin
            dir_v = dlast.sa ? -12'sd1 : 12'sd1;
            if (dlast.a == dlast.b) cmp_in = 12'sd0;
            else if (dlast.sa != dlast.sb) cmp_in = dlast.sb ? 12'sd1 : -12'sd1;
            else if (d != 0) cmp_in = dlast.sa ? -12'(d) : 12'(d);
            else cmp_in = (12'(signed'({1'b0, dlast.ma})) - 12'(signed'({1'b0, dlast.mb})))
                        * dir_v;
         end
         default: ;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (adv) va_ff <= dlastv;
      if (adv) begin
         raw_ff <= raw_in; exp_ff <= exp_in; rs_ff <= rs_in;
         cmp_ff <= cmp_in; dz_ff <= dz_in; opa_ff <= dlast.op;
      end
   end

   // ---- stage B: normalize to bit 10 and pack
   logic [3:0]  lz;
   logic [15:0] norm;
   logic [7:0]  ebias;
   logic [15:0] pack_in;
   logic        arith;
   always_comb begin
      lz    = lead_one(raw_ff);
      norm  = raw_ff << (4'd15 - lz);
      ebias = 8'(exp_ff) + 8'(lz) - 8'd10 + 8'd15;
      arith = (opa_ff == OP_ADD) || (opa_ff == OP_SUB) || (opa_ff == OP_MUL)
           || (opa_ff == OP_DIV);
      if (!arith || dz_ff) pack_in = 16'd0;
      else if (raw_ff == 16'd0) pack_in = {rs_ff && opa_ff != OP_ADD && opa_ff != OP_SUB, 15'd0};
      else pack_in = {rs_ff, ebias[4:0], norm[14:5]};
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (adv) rsp_valid <= va_ff;
      if (adv) begin
         rsp_result_bits    <= pack_in;
         rsp_compare_value  <= (opa_ff == OP_CMP) ? cmp_ff : 12'sd0;
         rsp_divide_by_zero <= dz_ff && (opa_ff == OP_DIV);
      end
   end

endmodule

// File: rtl/hfa_checker.sv
// hfa_checker: port-level checks for half_float_alu_core.
// Depends on hfa_pkg; bound into half_float_alu_core below.
module hfa_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [15:0]        rsp_result_bits,
   input logic signed [11:0] rsp_compare_value,
   input logic               rsp_divide_by_zero
);
   import hfa_pkg::*;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_result_bits == 16'd0)
      else $error("divide by zero with nonzero result");
   a_cmp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_value != 12'sd0 |-> rsp_result_bits == 16'd0
         && !rsp_divide_by_zero)
      else $error("compare and arithmetic result both set");
   a_stall_follow: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_bits))
      else $error("stalled word changed");
endmodule

bind half_float_alu_core hfa_checker u_hfa_checker (.*);

// File: verif/half_float_alu_core_test.sv
// half_float_alu_core_test: self-checking bench for the truncating half-float ALU.
// Depends on hfa_pkg and half_float_alu_core; predicts each result word and compares.
`timescale 1ns / 100ps

module half_float_alu_core_test;
   import hfa_pkg::*;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] a;
      logic [15:0] b;
   } op_word_type;

   typedef struct packed {
      logic [15:0]        bits;
      logic signed [11:0] cmp;
      logic               dz;
   } alu_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_op = '0;
   logic [15:0] req_operand_a = '0;
   logic [15:0] req_operand_b = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_result_bits;
   logic signed [11:0] rsp_compare_value;
   logic rsp_divide_by_zero;

   op_word_type  pending_ops[$];
   alu_word_type expected_words[$];
   int  mismatch_count = 0;
   int  sent_count = 0;
   int  taken_count = 0;
   int  send_idle_pct = 0;   // percent of cycles the sender holds off
   int  stall_pct = 0;       // percent of cycles the receiver stalls
   bit  hold_sender = 1'b0;  // pause issuing until the pipe drains
   logic word_taken = 1'b0;  // input word accepted at the last rising edge

   half_float_alu_core uut (.*);

   // Toggle every half period: 2 ns clock.
   always #1 clock = ~clock;

   // Unpack a half into sign, unbiased exponent and significand with hidden bit.
   function automatic logic [10:0] half_sig(input logic [15:0] h, output logic s,
                                            output int e);
      s = h[15];
      e = int'(h[14:10]) - 15;
      return {(h[14:0] != 15'd0), h[9:0]};
   endfunction

   // Normalize so the leading one lands at bit 10; exponent adjusted in place.
   function automatic logic [10:0] normalize(input logic [31:0] raw, inout int e);
      logic [15:0] v;
      v = raw[15:0];
      if (v == 16'd0) begin
         e = -15;
         return 11'd0;
      end
      while (!v[15]) begin
         v = v << 1;
         e = e - 1;
      end
      e = e + 5;
      return v[15:5];
   endfunction

   function automatic logic [15:0] pack_half(input logic s, input int e,
                                             input logic [10:0] m);
      logic [4:0] f;
      f = 5'(e + 15);
      return {s, f, m[9:0]};
   endfunction

   function automatic logic [15:0] sum_halves(input logic [15:0] a, input logic [15:0] b);
      logic sa, sb, rs;
      int ea, eb, d, ia, ib, total;
      logic [31:0] ma, mb;
      logic [10:0] m;
      ma = half_sig(a, sa, ea);
      mb = half_sig(b, sb, eb);
      d = ea - eb;
      if (d > 0) begin
         mb = (d >= 16) ? 0 : (mb >> d);
      end else begin
         ma = (-d >= 16) ? 0 : (ma >> (-d));
         ea = eb;
      end
      ia = sa ? -int'(ma) : int'(ma);
      ib = sb ? -int'(mb) : int'(mb);
      total = ia + ib;
      rs = 1'b0;
      if (total < 0) begin
         total = -total;
         rs = 1'b1;
      end
      m = normalize(32'(total), ea);
      return pack_half(rs, ea, m);
   endfunction

   // Work out the result word one operation causes.
   function automatic alu_word_type alu_result(input op_word_type w);
      alu_word_type r;
      logic sa, sb;
      int ea, eb, e, d, dir;
      logic [31:0] ma, mb, p;
      logic [10:0] m;
      r = '0;
      case (w.op)
         OP_ADD: r.bits = sum_halves(w.a, w.b);
         OP_SUB: r.bits = sum_halves(w.a, w.b ^ SIGN_MASK);
         OP_MUL: begin
            ma = half_sig(w.a, sa, ea) >> 3;
            mb = half_sig(w.b, sb, eb) >> 3;
            p = ma * mb;
            e = ea + eb - 4;
            m = normalize(p, e);
            r.bits = pack_half(sa ^ sb, e, m);
         end
         OP_DIV: begin
            ma = 32'(half_sig(w.a, sa, ea)) << 5;
            mb = half_sig(w.b, sb, eb) >> 3;
            if (mb == 0) begin
               r.dz = 1'b1;
            end else begin
               p = ma / mb;
               e = ea - eb + 2;
               m = normalize(p, e);
               r.bits = pack_half(sa ^ sb, e, m);
            end
         end
         OP_CMP: begin
            if (w.a != w.b) begin
               ma = half_sig(w.a, sa, ea);
               mb = half_sig(w.b, sb, eb);
               dir = sa ? -1 : 1;
               d = ea - eb;
               if (sa != sb) r.cmp = 12'(int'(sb) - int'(sa));
               else if (d != 0) r.cmp = 12'(d * dir);
               else r.cmp = 12'((int'(ma) - int'(mb)) * dir);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] rand_half();
      logic [15:0] h;
      h = 16'($urandom);
      case ($urandom_range(0, 7))
         0: h[14:0] = 15'd0;                      // signed zero
         1: h[14:10] = 5'd0;                      // exponent field zero
         2: h[14:10] = 5'h1f;                     // top exponent
         3: h[9:0] = 10'($urandom_range(0, 7));   // small fraction, fraction bits 9:3 zero
         default: ;
      endcase
      return h;
   endfunction

   task automatic queue_op(input logic [2:0] op, input logic [15:0] a, input logic [15:0] b);
      pending_ops.push_back('{op: op, a: a, b: b});
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_valid) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // Driver: hold the current word until taken, then advance at the falling edge.
   always @(negedge clock) begin
      op_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || word_taken) begin
         if (!hold_sender && pending_ops.size() != 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            w = pending_ops.pop_front();
            req_valid <= 1'b1;
            req_op <= w.op;
            req_operand_a <= w.a;
            req_operand_b <= w.b;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Monitor: sample both handshakes at the rising edge.
   always @(posedge clock) begin
      alu_word_type want;
      word_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_words.push_back(alu_result('{op: req_op, a: req_operand_a,
                                                   b: req_operand_b}));
            sent_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            taken_count++;
            if (expected_words.size() == 0) begin
               $error("result word with no expectation: bits %h", rsp_result_bits);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_result_bits !== want.bits) begin
                  $error("result_bits: expected %h, actual %h", want.bits, rsp_result_bits);
                  mismatch_count++;
               end
               if (rsp_compare_value !== want.cmp) begin
                  $error("compare_value: expected %0d, actual %0d", want.cmp,
                         rsp_compare_value);
                  mismatch_count++;
               end
               if (rsp_divide_by_zero !== want.dz) begin
                  $error("divide_by_zero: expected %b, actual %b", want.dz,
                         rsp_divide_by_zero);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      logic [2:0] op;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every op, signed zeros, divide by zero, equal patterns.
      queue_op(OP_ADD, 16'h3c00, 16'h3c00);
      queue_op(OP_ADD, 16'h3c00, 16'hbc00);      // cancels to zero
      queue_op(OP_ADD, 16'h7fff, 16'h0001);      // alignment wider than significand
      queue_op(OP_SUB, 16'hffff, 16'h7fff);
      queue_op(OP_SUB, 16'h0000, 16'h8000);
      queue_op(OP_MUL, 16'h0000, 16'h3c00);
      queue_op(OP_MUL, 16'h8000, 16'h3c00);      // zero product keeps sign
      queue_op(OP_MUL, 16'h7fff, 16'h7fff);      // exponent wrap
      queue_op(OP_MUL, 16'h0001, 16'hffff);
      queue_op(OP_DIV, 16'h3c00, 16'h0000);      // zero divisor
      queue_op(OP_DIV, 16'h3c00, 16'h8000);
      queue_op(OP_DIV, 16'h0000, 16'h3c00);
      queue_op(OP_DIV, 16'hffff, 16'h0001);
      queue_op(OP_DIV, 16'h7bff, 16'h03ff);
      queue_op(OP_CMP, 16'h1234, 16'h1234);
      queue_op(OP_CMP, 16'h0000, 16'h8000);      // +0 vs -0
      queue_op(OP_CMP, 16'h8000, 16'h0000);
      queue_op(OP_CMP, 16'h7c00, 16'h0400);
      queue_op(OP_CMP, 16'hfc00, 16'h8400);
      queue_op(OP_CMP, 16'h3fff, 16'h3c00);
      queue_op(OP_CMP, 16'hbc00, 16'hbfff);
      queue_op(3'd5, 16'hffff, 16'hffff);        // unused codes
      queue_op(3'd6, 16'h1234, 16'h4321);
      queue_op(3'd7, 16'h0000, 16'hffff);
      wait_drained();

      // Random phases: none, sender idle, receiver stalling, both.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 88 : (phase == 3) ? 19 : 0;
         stall_pct = (phase == 2) ? 88 : (phase == 3) ? 19 : 0;
         for (int i = 0; i < 162; i++) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            if (op == OP_CMP && $urandom_range(0, 3) == 0) begin
               logic [15:0] h;
               h = rand_half();
               queue_op(op, h, ($urandom_range(0, 1) != 0) ? h : (h ^ 16'h0001));
            end else begin
               queue_op(op, rand_half(), rand_half());
            end
         end
         if (phase == 0) begin
            // Hold the sender once until the pipe has fully drained.
            repeat (81) @(posedge clock);
            hold_sender = 1'b1;
            while (expected_words.size() != 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         wait_drained();
      end
      stall_pct = 0;
      repeat (40) @(posedge clock);

      $display("Sent %0d operation words, checked %0d result words", sent_count, taken_count);
      $display("Covered add, subtract, multiply, divide, compare and unused codes under four idle mixes");
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Guard against a hung pipe.
   initial begin
      #400000;
      $display("Mismatches found");
      $finish;
   end

endmodule
